// File: rtl/lrg_pkg.sv
// ----------------------------------------------------------------------------
// Lehmer random generator package
// Shared widths, constants, sequencer states and control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lrg_pkg;

  // Field widths.
  localparam int RAW_W  = 31;
  localparam int VAL_W  = 16;
  localparam int DIFF_W = VAL_W + 1;
  localparam int OPA_W  = 32;
  localparam int OPB_W  = DIFF_W;
  localparam int PROD_W = OPA_W + OPB_W;

  // Generator constants.
  localparam logic [RAW_W-1:0]        LCG_MOD    = 31'h7fffffff;
  localparam logic [RAW_W-1:0]        ZERO_SUBST = 31'd123459876;
  localparam logic signed [OPB_W-1:0] LCG_MULT   = 17'sd16807;
  localparam logic [VAL_W:0]          SIGNED_MOD = 17'd65535;
  localparam logic [VAL_W-1:0]        SIGNED_OFS = 16'd32767;
  localparam logic [PROD_W-1:0]       TRUNC_ADJ  = 49'd65535;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_STATE,
    ST_REDUCE,
    ST_FOLD16,
    ST_MUL_RANGE,
    ST_FINISH
  } seq_state_t;

  // Control bundle from the sequencer to the datapath.
  typedef struct packed {
    logic ready;
    logic in_load;
    logic mul_state;
    logic state_update;
    logic uval_load;
    logic mul_range;
    logic out_load;
  } ctrl_t;

endpackage

`default_nettype wire

// File: rtl/lrg_req_if.sv
// ----------------------------------------------------------------------------
// Lehmer random generator request channel
// Carries the range bounds of one draw with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrg_req_if;
  import lrg_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] range_min;
  logic [VAL_W-1:0] range_max;

  modport source (output valid, output range_min, output range_max, input ready);
  modport sink (input valid, input range_min, input range_max, output ready);

endinterface

`default_nettype wire

// File: rtl/lrg_res_if.sv
// ----------------------------------------------------------------------------
// Lehmer random generator result channel
// Carries the four values of one draw with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrg_res_if;
  import lrg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [RAW_W-1:0]        raw_value;
  logic signed [VAL_W-1:0] signed_value;
  logic [VAL_W-1:0]        unsigned_value;
  logic [VAL_W-1:0]        ranged_value;

  modport source (output valid, output raw_value, output signed_value,
                  output unsigned_value, output ranged_value, input ready);
  modport sink (input valid, input raw_value, input signed_value,
                input unsigned_value, input ranged_value, output ready);

endinterface

`default_nettype wire

// File: rtl/lehmer_random_generator.sv
// ----------------------------------------------------------------------------
// Lehmer random generator
// Park-Miller minimal standard generator with signed and ranged outputs.
// ----------------------------------------------------------------------------
// Each request transaction performs one draw: a zero state is replaced by
// 123459876, the state becomes 16807 * state mod (2^31 - 1), and the result
// transaction carries the new state, (state mod 65535) - 32767 as signed and
// unsigned 16-bit values, and range_min plus that unsigned value scaled by
// (range_max - range_min) / 65536, truncated toward zero, wrapped to 16 bits.
// A draw steps from the accepted request through the state multiply, the
// state reduction, the 16-bit fold and the range multiply to the result
// register, one shared multiplier used twice in sequence; no request is
// taken mid-draw. A new request is accepted in the cycle after the
// result is loaded, even while that result still waits, but that next draw
// then holds in its last step until the waiting result is taken.
// Writing seed_data with seed_we high loads the state; write it only while
// no draw is in flight.
`default_nettype none

module lehmer_random_generator (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      seed_we,
  input  wire logic [lrg_pkg::RAW_W-1:0] seed_data,
  lrg_req_if.sink                        req,
  lrg_res_if.source                      res
);
  import lrg_pkg::*;

  ctrl_t                    ctrl;
  logic [RAW_W-1:0]         gen_state;
  logic [VAL_W-1:0]         lo;
  logic signed [DIFF_W-1:0] range;
  logic [VAL_W-1:0]         uval;
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic [RAW_W-1:0]         state_in;
  logic [RAW_W:0]           fold31;
  logic [RAW_W-1:0]         reduced;
  logic [VAL_W:0]           fold16;
  logic [VAL_W:0]           mod16;
  logic [PROD_W-1:0]        prod_adj;
  logic [VAL_W-1:0]         ranged;
  logic                     out_free;

  assign out_free  = !res.valid || res.ready;
  assign req.ready = ctrl.ready;

  lrg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Operand selection for the shared multiplier.
  assign state_in = (gen_state == '0) ? ZERO_SUBST : gen_state;
  always_comb begin
    if (ctrl.mul_range) begin
      op_a = signed'({{(OPA_W-VAL_W){1'b0}}, uval});
      op_b = range;
    end else begin
      op_a = signed'({{(OPA_W-RAW_W){1'b0}}, state_in});
      op_b = LCG_MULT;
    end
  end

  lrg_mul u_mul (
    .clk  (clk),
    .en   (ctrl.mul_state || ctrl.mul_range),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // Modulo 2^31-1: add the high part onto the low 31 bits, subtract once.
  assign fold31  = {1'b0, prod[RAW_W-1:0]}
                 + {{(2*RAW_W+1-PROD_W){1'b0}}, prod[PROD_W-1:RAW_W]};
  assign reduced = (fold31 >= {1'b0, LCG_MOD}) ? RAW_W'(fold31 - {1'b0, LCG_MOD})
                                                : fold31[RAW_W-1:0];

  // Modulo 65535: add the high half onto the low half, subtract once.
  assign fold16 = {1'b0, gen_state[VAL_W-1:0]}
                + {{(2*VAL_W+1-RAW_W){1'b0}}, gen_state[RAW_W-1:VAL_W]};
  assign mod16  = (fold16 >= SIGNED_MOD) ? (fold16 - SIGNED_MOD) : fold16;

  // Divide by 65536 truncating toward zero: bias negative products first.
  assign prod_adj = prod[PROD_W-1] ? (PROD_W'(prod) + TRUNC_ADJ) : PROD_W'(prod);
  assign ranged   = prod_adj[2*VAL_W-1:VAL_W] + lo;

  // Generator state: seed writes and draw updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= RAW_W'(1);
    end else if (seed_we) begin
      gen_state <= seed_data;
    end else if (ctrl.state_update) begin
      gen_state <= reduced;
    end
  end

  // Request capture and intermediate value.
  always_ff @(posedge clk) begin
    if (ctrl.in_load) begin
      lo    <= req.range_min;
      range <= signed'({1'b0, req.range_max}) - signed'({1'b0, req.range_min});
    end
    if (ctrl.uval_load) begin
      uval <= mod16[VAL_W-1:0] - SIGNED_OFS;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctrl.out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      res.raw_value      <= gen_state;
      res.signed_value   <= signed'(uval);
      res.unsigned_value <= uval;
      res.ranged_value   <= ranged;
    end
  end

`ifndef SYNTHESIS
  // A draw never leaves the state at the modulus itself.
  a_raw_reduced: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.raw_value != LCG_MOD)
    else $error("raw_value equals the modulus");

  // The signed value stays within -32767..32767.
  a_signed_span: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> res.signed_value != 16'sh8000)
    else $error("signed_value out of range");

  // An accepted request keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while a draw is in flight");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> out_free)
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// File: rtl/lrg_mul.sv
// ----------------------------------------------------------------------------
// Lehmer random generator shared multiplier
// Signed 32 x 17 multiplier with a registered product, used for both the
// state update and the range scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module lrg_mul (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [lrg_pkg::OPA_W-1:0]     op_a,
  input  wire logic signed [lrg_pkg::OPB_W-1:0]     op_b,
  output logic signed [lrg_pkg::PROD_W-1:0]         prod
);
  import lrg_pkg::*;

  // Product register, loaded only when the sequencer asks for a multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule

`default_nettype wire

// File: rtl/lrg_seq.sv
// ----------------------------------------------------------------------------
// Lehmer random generator sequencer
// Steps one draw through multiply, reduction, fold, range multiply and
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lrg_seq (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       out_free,
  output lrg_pkg::ctrl_t  ctrl
);
  import lrg_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL_STATE;
      end
      ST_MUL_STATE: state_next = ST_REDUCE;
      ST_REDUCE:    state_next = ST_FOLD16;
      ST_FOLD16:    state_next = ST_MUL_RANGE;
      ST_MUL_RANGE: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE: begin
        ctrl.ready   = 1'b1;
        ctrl.in_load = in_valid;
      end
      ST_MUL_STATE: ctrl.mul_state    = 1'b1;
      ST_REDUCE:    ctrl.state_update = 1'b1;
      ST_FOLD16:    ctrl.uval_load    = 1'b1;
      ST_MUL_RANGE: ctrl.mul_range    = 1'b1;
      ST_FINISH:    ctrl.out_load     = out_free;
      default:      ctrl = '0;
    endcase
  end

endmodule

`default_nettype wire
